/* hdl/mtlbp_pkg.sv */
// Shared types and constants for the mean-threshold LBP block.
`default_nettype none
package mtlbp_pkg;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned CRD_W  = 11;
    localparam int unsigned CFG_W  = 12;
    localparam int unsigned IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_DIVISOR = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAP_EN  = 2'd3;

    localparam logic MODE_TABLE = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
    } t_column;

    // commands from controller to datapath
    typedef struct packed {
        logic             load;      // window shift
        logic             first_col; // fill left columns with the new one
        logic             row_zero;  // top = mid = pixel
        logic             row_one;   // top = mid
        logic [1:0]       variant;   // which result to form
        logic             emit;      // present a result
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
        logic             last;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
    } t_dp_status;

    // variant codes
    localparam logic [1:0] VAR_NORMAL      = 2'd0;
    localparam logic [1:0] VAR_BOTTOM      = 2'd1;
    localparam logic [1:0] VAR_EDGE        = 2'd2;
    localparam logic [1:0] VAR_EDGE_BOTTOM = 2'd3;

    // weights by window row, column
    function automatic logic [7:0] weight_of(input logic [1:0] r, input logic [1:0] c);
        logic [7:0] w;
        begin
            w = 8'd0;
            case ({r, c})
                4'b0000: w = 8'd64;
                4'b0001: w = 8'd128;
                4'b0010: w = 8'd1;
                4'b0100: w = 8'd32;
                4'b0101: w = 8'd0;
                4'b0110: w = 8'd2;
                4'b1000: w = 8'd16;
                4'b1001: w = 8'd8;
                4'b1010: w = 8'd4;
                default: w = 8'd0;
            endcase
            weight_of = w;
        end
    endfunction
endpackage
`default_nettype wire

/* hdl/mtlbp_in_if.sv */
// Input channel interface.
`default_nettype none
interface mtlbp_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] pixel;
    logic [7:0] table_index;
    logic [7:0] table_value;
    modport source (output valid, mode, pixel, table_index, table_value, input ready);
    modport sink   (input valid, mode, pixel, table_index, table_value, output ready);
endinterface
`default_nettype wire

/* hdl/mtlbp_out_if.sv */
// Output channel interface.
`default_nettype none
interface mtlbp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  code;
    logic [10:0] out_row;
    logic [10:0] out_col;
    logic        frame_last;
    modport source (output valid, code, out_row, out_col, frame_last, input ready);
    modport sink   (input valid, code, out_row, out_col, frame_last, output ready);
endinterface
`default_nettype wire

/* hdl/mtlbp_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module mtlbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* hdl/mtlbp_div.sv */
// Restoring divider of the window sum by the configured divisor.
`default_nettype none
module mtlbp_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [11:0] i_num,
    input  wire logic [4:0]  i_den,
    output logic             o_done,
    output logic [11:0]      o_quo
);
    logic [3:0]  r_cnt;
    logic        r_run;
    logic [11:0] r_q;
    logic [12:0] r_rem;
    logic [4:0]  r_den;
    logic [12:0] n_rem;
    logic [12:0] n_sub;

    always_comb begin
        n_rem = {r_rem[11:0], r_q[11]};
        n_sub = n_rem - {8'd0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= !i_start && r_run && (r_cnt == 4'd11);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_q   <= i_num;
                r_rem <= '0;
                r_den <= (i_den == 5'd0) ? 5'd1 : i_den;
            end else if (r_run) begin
                if (!n_sub[12]) begin
                    r_rem <= n_sub;
                    r_q   <= {r_q[10:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[10:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd11) begin
                    r_run <= 1'b0;
                end
            end
        end
    end
    assign o_quo = r_q;
endmodule
`default_nettype wire

/* hdl/mtlbp_datapath.sv */
// Window registers, threshold and code mapping datapath.
`default_nettype none
module mtlbp_datapath (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mtlbp_pkg::t_dp_cmd    i_cmd,
    input  wire mtlbp_pkg::t_column    i_colin,
    input  wire logic [4:0]            i_divisor,
    input  wire logic                  i_map_en,
    input  wire logic                  i_tbl_we,
    input  wire logic [7:0]            i_tbl_idx,
    input  wire logic [7:0]            i_tbl_val,
    input  wire logic                  i_start,
    output logic                       o_done,
    output logic [7:0]                 o_code
);
    import mtlbp_pkg::*;

    logic [7:0] r_win [3][3];
    logic [7:0] n_top, n_mid;
    logic [7:0] u [3][3];
    logic [11:0] sum;
    logic [11:0] quo;
    logic        div_done;
    logic [7:0]  raw;
    logic [7:0]  r_raw;
    logic        r_map_wait;
    logic [7:0]  map_q;
    logic        r_done;

    always_comb begin
        n_mid = i_cmd.row_zero ? i_colin.pixel : i_colin.mid;
        n_top = i_cmd.row_zero ? i_colin.pixel : (i_cmd.row_one ? n_mid : i_colin.top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                logic [7:0] v;
                v = (i == 0) ? n_top : (i == 1) ? n_mid : i_colin.pixel;
                r_win[i][0] <= i_cmd.first_col ? v : r_win[i][1];
                r_win[i][1] <= i_cmd.first_col ? v : r_win[i][2];
                r_win[i][2] <= v;
            end
        end
    end

    // window variant for the current result
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                logic [1:0] rs;
                logic [1:0] cs;
                rs = i[1:0];
                if (i_cmd.variant[0]) begin
                    rs = (i == 2) ? 2'd2 : rs + 2'd1;
                end
                cs = j[1:0];
                if (i_cmd.variant[1]) begin
                    cs = (j == 2) ? 2'd2 : cs + 2'd1;
                end
                u[i][j] = r_win[rs][cs];
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sum = sum + {4'd0, u[i][j]};
            end
        end
        raw = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if ({4'd0, u[i][j]} >= quo) begin
                    raw = raw + weight_of(i[1:0], j[1:0]);
                end
            end
        end
    end

    mtlbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_num   (sum),
        .i_den   (i_divisor),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    mtlbp_ram #(.WIDTH(8), .DEPTH(256)) u_map (
        .i_clk   (i_clk),
        .i_we    (i_tbl_we),
        .i_waddr (i_tbl_idx),
        .i_wdata (i_tbl_val),
        .i_raddr (raw),
        .o_rdata (map_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_wait <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done     <= r_map_wait;
            r_map_wait <= div_done;
            if (div_done) begin
                r_raw <= raw;
            end
        end
    end

    assign o_done = r_done;
    assign o_code = i_map_en ? map_q : r_raw;
endmodule
`default_nettype wire

/* hdl/mtlbp_ctrl.sv */
// Controller: counters, line stores and result sequencing.
`default_nettype none
module mtlbp_ctrl #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_acc,
    input  wire logic                   i_mode,
    input  wire logic [7:0]             i_pixel,
    input  wire logic [11:0]            i_width,
    input  wire logic [11:0]            i_height,
    input  wire logic                   i_done,
    input  wire logic                   i_out_take,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    output mtlbp_pkg::t_dp_cmd          o_cmd,
    output mtlbp_pkg::t_column          o_col,
    output logic                        o_start
);
    import mtlbp_pkg::*;
    localparam int unsigned AW   = $clog2(MAX_WIDTH);
    localparam int unsigned WLIM = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_LOAD, S_CALC, S_WAIT, S_SHOW} t_state;
    t_state r_state;

    logic [CRD_W-1:0] r_row, r_col;
    logic [7:0]       r_pix;
    logic [AW-1:0]    r_idx;
    logic [3:0]       r_mask;  // pending variants, bit order: normal,bottom,edge,edge_bottom
    logic [1:0]       r_var;
    logic             r_lastrow, r_lastcol;
    logic             r_start;
    logic [11:0]      w, h;
    logic [7:0]       up_q, lo_q;
    logic             we;
    logic [3:0]       n_mask;
    logic [1:0]       next_var;
    logic             have_next;

    always_comb begin
        w = (i_width < 12'd2) ? 12'd2 : (i_width > WLIM[11:0]) ? WLIM[11:0] : i_width;
        h = (i_height < 12'd2) ? 12'd2 : (i_height > 12'd2048) ? 12'd2048 : i_height;
    end

    assign we = (r_state == S_LOAD);

    mtlbp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_idx), .i_wdata(lo_q),
        .i_raddr(r_idx), .o_rdata(up_q));
    mtlbp_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lower (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_idx), .i_wdata(r_pix),
        .i_raddr(r_idx), .o_rdata(lo_q));

    // lowest pending variant
    always_comb begin
        have_next = 1'b1;
        next_var  = VAR_NORMAL;
        n_mask    = r_mask;
        if (r_mask[0]) begin
            next_var = VAR_NORMAL;
            n_mask[0] = 1'b0;
        end else if (r_mask[1]) begin
            next_var = VAR_BOTTOM;
            n_mask[1] = 1'b0;
        end else if (r_mask[2]) begin
            next_var = VAR_EDGE;
            n_mask[2] = 1'b0;
        end else if (r_mask[3]) begin
            next_var = VAR_EDGE_BOTTOM;
            n_mask[3] = 1'b0;
        end else begin
            have_next = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_start <= 1'b0;
            r_mask  <= '0;
            r_var   <= VAR_NORMAL;
        end else begin
            r_start <= (r_state == S_CALC) && have_next;
            case (r_state)
                S_IDLE: begin
                    if (i_acc && i_mode == MODE_PIXEL) begin
                        r_pix   <= i_pixel;
                        r_idx   <= (32'(r_col) < MAX_WIDTH) ?
                                   AW'(r_col) : AW'(MAX_WIDTH - 1);
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    r_lastcol <= ({1'b0, r_col} >= w - 12'd1);
                    r_lastrow <= ({1'b0, r_row} >= h - 12'd1);
                    r_mask <= (r_row == '0) ? 4'd0 : {
                        ({1'b0, r_col} >= w - 12'd1) && ({1'b0, r_row} >= h - 12'd1),
                        ({1'b0, r_col} >= w - 12'd1),
                        (r_col != '0) && ({1'b0, r_row} >= h - 12'd1),
                        (r_col != '0)};
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (have_next) begin
                        r_var   <= next_var;
                        r_mask  <= n_mask;
                        r_state <= S_WAIT;
                    end else begin
                        if (r_lastcol) begin
                            r_col <= '0;
                            r_row <= r_lastrow ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_WAIT: if (i_done) r_state <= S_SHOW;
                S_SHOW: if (i_out_take) r_state <= S_CALC;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_LOAD);
        o_cmd.first_col = (r_col == '0);
        o_cmd.row_zero  = (r_row == '0);
        o_cmd.row_one   = (r_row == 11'd1);
        o_cmd.variant   = r_var;
        o_cmd.emit      = (r_state == S_SHOW);
        o_cmd.row       = r_var[0] ? r_row : r_row - 1'b1;
        o_cmd.col       = r_var[1] ? r_col : r_col - 1'b1;
        o_cmd.last      = (r_var == VAR_EDGE_BOTTOM);
        o_col.pixel     = r_pix;
        o_col.mid       = lo_q;
        o_col.top       = up_q;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_SHOW);
    assign o_start     = r_start;
endmodule
`default_nettype wire

/* hdl/mean_threshold_lbp_mapped.sv */
// Top level of the mean-threshold LBP block with code mapping.
//
// channel   dir  payload                                 transfer when
// in_ch     in   mode, pixel, table_index, table_value   valid && ready
// out_ch    out  code, out_row, out_col, frame_last      valid && ready
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data         i_cfg_we high
//
// A pixel passes through accept, line-store read, window load and a final
// sequencing step, plus for each of its 0..4 results: launch, 12-step serial
// divider, hand-back and table read, and an output transfer when the receiver
// is ready.
// Reset (i_rst_n low, synchronous) clears counters, window and registers;
// line stores and map table keep no reset. A stalled output holds the block.
`default_nettype none
module mean_threshold_lbp_mapped #(
    parameter int unsigned MAX_WIDTH   = 2048,
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [11:0] i_cfg_data,
    mtlbp_in_if.sink         in_ch,
    mtlbp_out_if.source      out_ch
);
    import mtlbp_pkg::*;

    logic [11:0] r_width, r_height;
    logic [4:0]  r_div;
    logic        r_map;
    t_dp_cmd     cmd;
    t_column     col;
    logic        start, done, tbl_we, acc;
    logic [7:0]  code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
            r_div    <= 5'd9;
            r_map    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:   r_width  <= i_cfg_data;
                REG_HEIGHT:  r_height <= i_cfg_data;
                REG_DIVISOR: r_div    <= i_cfg_data[4:0];
                REG_MAP_EN:  r_map    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign acc    = in_ch.valid && in_ch.ready;
    assign tbl_we = acc && (in_ch.mode == MODE_TABLE) && (TABLE_DEPTH == 256);

    mtlbp_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_acc(acc), .i_mode(in_ch.mode),
        .i_pixel(in_ch.pixel), .i_width(r_width), .i_height(r_height),
        .i_done(done), .i_out_take(out_ch.ready), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .o_cmd(cmd), .o_col(col), .o_start(start));

    mtlbp_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_colin(col),
        .i_divisor(r_div), .i_map_en(r_map), .i_tbl_we(tbl_we),
        .i_tbl_idx(in_ch.table_index), .i_tbl_val(in_ch.table_value),
        .i_start(start), .o_done(done), .o_code(code));

    assign out_ch.code       = code;
    assign out_ch.out_row    = cmd.row;
    assign out_ch.out_col    = cmd.col;
    assign out_ch.frame_last = cmd.last;
endmodule
`default_nettype wire
